// ----- sv/cfse_pkg.sv -----
// ----------------------------------------------------------------------------
// cfse_pkg
// Types and constants shared by the command frame stuffing encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfse_pkg;

    localparam logic [7:0]  START_BYTE_0 = 8'hAA;
    localparam logic [7:0]  START_BYTE_1 = 8'hBB;
    localparam logic [7:0]  STUFF_BYTE   = 8'h00;
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;
    localparam logic [15:0] LEN_OFFSET   = 16'd5;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        JOB_HDR,
        JOB_DATA
    } job_kind_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] cmd_code;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] len_field;
        logic [15:0] cmd_code;
        logic [7:0]  data_byte;
        logic [7:0]  check_byte;
        logic        last;
    } job_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } queue_stat_t;

endpackage

`default_nettype wire

// ----- sv/cfse_front.sv -----
// ----------------------------------------------------------------------------
// cfse_front
// Accepts input items, tracks the open frame and the running check byte,
// and hands one job per producing item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cfse_pkg::in_item_t s_item,
    input  wire cfse_pkg::queue_stat_t q_stat,
    output logic                   push,
    output cfse_pkg::job_t         push_job
);

    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  check_acc_reg, check_acc_next;
    logic        frame_open_reg, frame_open_next;

    logic        accept;
    logic [15:0] len_field;
    logic [7:0]  hdr_check;
    logic [7:0]  data_check;
    logic [15:0] left_dec;

    assign s_ready = q_stat.not_full;
    assign accept  = s_valid && s_ready;

    assign len_field  = s_item.payload_len + cfse_pkg::LEN_OFFSET;
    assign hdr_check  = len_field[15:8] ^ s_item.cmd_code[7:0] ^ s_item.cmd_code[15:8];
    assign data_check = check_acc_reg ^ s_item.data_byte;
    assign left_dec   = bytes_left_reg - 16'd1;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        check_acc_next  = check_acc_reg;
        frame_open_next = frame_open_reg;
        push            = 1'b0;
        push_job.kind       = cfse_pkg::JOB_HDR;
        push_job.len_field  = len_field;
        push_job.cmd_code   = s_item.cmd_code;
        push_job.data_byte  = s_item.data_byte;
        push_job.check_byte = hdr_check;
        push_job.last       = 1'b0;
        if (accept) begin
            if (s_item.mode == cfse_pkg::MODE_START) begin
                push            = 1'b1;
                push_job.last   = (s_item.payload_len == 16'd0);
                bytes_left_next = s_item.payload_len;
                frame_open_next = (s_item.payload_len != 16'd0);
                check_acc_next  = (s_item.payload_len == 16'd0) ? 8'd0 : hdr_check;
            end else if (frame_open_reg) begin
                push                = 1'b1;
                push_job.kind       = cfse_pkg::JOB_DATA;
                push_job.check_byte = data_check;
                push_job.last       = (left_dec == 16'd0);
                bytes_left_next     = left_dec;
                frame_open_next     = (left_dec != 16'd0);
                check_acc_next      = (left_dec == 16'd0) ? 8'd0 : data_check;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            check_acc_reg  <= '0;
            frame_open_reg <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            check_acc_reg  <= check_acc_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cfse_queue.sv -----
// ----------------------------------------------------------------------------
// cfse_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cfse_pkg::job_t   push_job,
    input  wire logic             pop,
    output cfse_pkg::job_t        head_job,
    output cfse_pkg::queue_stat_t q_stat
);

    cfse_pkg::job_t entry_reg [cfse_pkg::QUEUE_DEPTH];

    logic [cfse_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cfse_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cfse_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign q_stat.not_full  = (count_reg != (cfse_pkg::QUEUE_AW+1)'(cfse_pkg::QUEUE_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign head_job         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cfse_back.sv -----
// ----------------------------------------------------------------------------
// cfse_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfse_pkg::job_t   head_job,
    input  wire cfse_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cfse_pkg::out_item_t   m_item
);

    logic [3:0]          step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    cfse_pkg::out_item_t m_item_reg;

    logic                load;
    logic                stuff;
    logic [3:0]          n_bytes;
    logic                final_step;
    logic [7:0]          cur_byte;

    assign stuff = (head_job.data_byte == cfse_pkg::START_BYTE_0);

    always_comb begin
        case (head_job.kind)
            cfse_pkg::JOB_HDR:  n_bytes = 4'd8 + {3'd0, head_job.last};
            cfse_pkg::JOB_DATA: n_bytes = 4'd1 + {3'd0, stuff} + {3'd0, head_job.last};
            default:            n_bytes = 4'd1;
        endcase
    end

    always_comb begin
        cur_byte = head_job.check_byte;
        case (head_job.kind)
            cfse_pkg::JOB_HDR: begin
                case (step_reg)
                    4'd0:    cur_byte = cfse_pkg::START_BYTE_0;
                    4'd1:    cur_byte = cfse_pkg::START_BYTE_1;
                    4'd2:    cur_byte = head_job.len_field[7:0];
                    4'd3:    cur_byte = head_job.len_field[15:8];
                    4'd4:    cur_byte = cfse_pkg::ZERO_BYTE;
                    4'd5:    cur_byte = cfse_pkg::ZERO_BYTE;
                    4'd6:    cur_byte = head_job.cmd_code[7:0];
                    4'd7:    cur_byte = head_job.cmd_code[15:8];
                    default: cur_byte = head_job.check_byte;
                endcase
            end
            cfse_pkg::JOB_DATA: begin
                case (step_reg)
                    4'd0:    cur_byte = head_job.data_byte;
                    4'd1:    cur_byte = stuff ? cfse_pkg::STUFF_BYTE : head_job.check_byte;
                    default: cur_byte = head_job.check_byte;
                endcase
            end
            default: cur_byte = head_job.check_byte;
        endcase
    end

    assign final_step = (step_reg == n_bytes - 4'd1);
    assign load       = q_stat.not_empty && (!m_valid_reg || m_ready);
    assign pop        = load && final_step;

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            step_next    = final_step ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg.out_byte  <= cur_byte;
            m_item_reg.frame_end <= final_step && head_job.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ----- sv/command_frame_stuffing_encoder.sv -----
// ----------------------------------------------------------------------------
// command_frame_stuffing_encoder
// Serial command frame builder with 0xAA byte stuffing and XOR check byte.
//
//   channel  dir  payload     handshake
//   s_       in   in_item_t   s_valid / s_ready
//   m_       out  out_item_t  m_valid / m_ready
//
// the front takes one item per cycle while the four-entry job queue has room
// the back sends one byte per cycle while m_ready holds: a start item sends
// 8 or 9 bytes, a data item 1 to 3; the byte sequencer sets the sustained rate
// a data item with no open frame is taken and sends nothing
// aresetn clears frame state, queue and output valid; either side may stall
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_stuffing_encoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cfse_pkg::in_item_t s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cfse_pkg::out_item_t     m_item
);

    cfse_pkg::queue_stat_t q_stat;
    cfse_pkg::job_t        push_job;
    cfse_pkg::job_t        head_job;
    logic                  push;
    logic                  pop;

    cfse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    cfse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    cfse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire
